### hdl/tdad_pkg.sv
// Shared types and constants for the telemetry drift anomaly detector.
// Used by the top level and by the port checker; no dependencies.

package tdad_pkg;

   // field widths
   localparam int DAY_W    = 16;
   localparam int TEMP_W   = 16;
   localparam int Z_W      = 24;
   localparam int START_W  = 17;
   localparam int RUL_W    = 24;

   // internal accumulator widths, sized for the largest BASELINE and WINDOW
   localparam int SUM_W    = 24;
   localparam int SQ_W     = 40;
   localparam int WS_W     = 24;
   localparam int WWS_W    = 32;
   localparam int NUM_W    = 40;
   localparam int DIV_W    = 48;

   // stream and register port widths
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 112;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // result word layout (lowest bit first)
   localparam int RSP_DAY_LSB    = 0;
   localparam int RSP_Z_LSB      = 16;
   localparam int RSP_EWMA_LSB   = 40;
   localparam int RSP_STATUS_LSB = 64;
   localparam int RSP_FOUND_BIT  = 66;
   localparam int RSP_START_LSB  = 67;
   localparam int RSP_RULV_BIT   = 84;
   localparam int RSP_RUL_LSB    = 85;

   localparam logic signed [Z_W-1:0] Z_MAX = 24'sh7FFFFF;
   localparam logic signed [Z_W-1:0] Z_MIN = -24'sh800000;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ALPHA   = 3'd0,
      CSR_THRESH  = 3'd1,
      CSR_SUSTAIN = 3'd2,
      CSR_CRIT    = 3'd3,
      CSR_WARN    = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_WARNING  = 2'd1,
      ST_CRITICAL = 2'd2
   } status_type;

   // clamp a wide signed value to the 24-bit result range
   function automatic logic signed [Z_W-1:0] sat24(input logic signed [DIV_W:0] v);
      logic signed [Z_W-1:0] r;
      if (v > (DIV_W+1)'(Z_MAX)) begin
         r = Z_MAX;
      end else if (v < (DIV_W+1)'(Z_MIN)) begin
         r = Z_MIN;
      end else begin
         r = v[Z_W-1:0];
      end
      return r;
   endfunction

endpackage

### hdl/telemetry_drift_anomaly_detector_unit.sv
// Drift anomaly detector: baseline buffer, z-score, EWMA, run counter, remaining life.
// Depends on tdad_pkg and tdad_ram. One word in flight at a time.
// Scored word: one 48-step shared divider, plus the remaining-life path when it runs
//   (ring read through one port, second divide).
// Baseline close: mean divide, variance divide, 16-step sqrt,
//   then each buffered sample is scored as above. Reset is synchronous, active high.

module telemetry_drift_anomaly_detector_unit #(
   parameter int BASELINE = 20,
   parameter int WINDOW   = 14
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // req_tdata: day [15:0], temperature [31:16]; req_tlast: series_end
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [tdad_pkg::REQ_DATA_W-1:0]      req_tdata,
   input  logic                                 req_tlast,
   // rsp_tdata: sample_day, z_score, smoothed_z, status, anomaly_found,
   //   start day, rul_valid, rul_days, zero pad; rsp_tlast: last_result
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [tdad_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic                                 rsp_tlast,
   input  logic                                 csr_we,
   input  logic [tdad_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [tdad_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int BA_W     = $clog2(BASELINE);
   localparam int BC_W     = $clog2(BASELINE + 1);
   localparam int RA_W     = $clog2(WINDOW);
   localparam int RK_W     = $clog2(WINDOW + 1);
   localparam int SC_LIMIT = 2 * WINDOW + 1;
   localparam int SC_W     = $clog2(SC_LIMIT + 1);
   localparam int DC_W     = $clog2(tdad_pkg::DIV_W + 1);
   localparam longint WIN_SX  = WINDOW * (WINDOW - 1) / 2;
   localparam longint WIN_SXX = (WINDOW - 1) * WINDOW * (2 * WINDOW - 1) / 6;
   localparam longint WIN_DEN = WINDOW * WIN_SXX - WIN_SX * WIN_SX;
   localparam logic [23:0] DEN_C = 24'(WIN_DEN);
   localparam logic signed [47:0] DEN_X256 = 48'(WIN_DEN * 256);

   localparam int DW = tdad_pkg::DIV_W;

   typedef enum logic [4:0] {
      S_IDLE, S_BASE_ACC, S_BASE_CHK, S_MEAN_LD, S_MEAN_DIV, S_VAR_MUL, S_VAR_LD,
      S_VAR_DIV, S_SQRT, S_SC_RD, S_SC_RDW, S_SC_START, S_Z_DIV, S_EW1, S_EW2,
      S_EW3, S_ANOM, S_WIN_INIT, S_WIN_RD, S_SLOPE1, S_SLOPE2, S_RUL_DIV, S_EMIT,
      S_FIN
   } state_type;

   state_type state_ff;

   // configuration
   logic [15:0] alpha_ff, thresh_ff, sustain_ff;
   logic [14:0] crit_ff;
   logic [7:0]  warn_ff;

   // accepted word and the sample being scored
   logic [15:0]        in_day_ff, cur_day_ff;
   logic signed [15:0] in_temp_ff, cur_temp_ff;
   logic               in_end_ff, cur_last_ff;

   // series state
   logic [BC_W-1:0]                    bcount_ff;
   logic signed [tdad_pkg::SUM_W-1:0]  sum_ff;
   logic [tdad_pkg::SQ_W-1:0]          sumsq_ff;
   logic signed [15:0]                 mean_ff;
   logic [15:0]                        dev_ff;
   logic [SC_W-1:0]                    scount_ff;
   logic signed [23:0]                 ewma_ff;
   logic                               started_ff;
   logic [15:0]                        run_ff;
   logic                               flag_ff;
   logic signed [17:0]                 start_ff;
   logic [RA_W-1:0]                    pos_ff;
   logic [BA_W-1:0]                    idx_ff;

   // shared divider
   logic [DW:0]      div_rem_ff;
   logic [DW-1:0]    div_quo_ff, div_dvs_ff;
   logic [DC_W-1:0]  div_cnt_ff;
   logic             div_neg_ff;

   // products and sqrt
   logic signed [DW-1:0] prod_a_ff, prod_b_ff;
   logic signed [DW:0]   acc_ff;
   logic [31:0]          sq_v_ff, sq_r_ff, sq_bit_ff;

   // per-result values
   logic signed [23:0]          z_ff;
   tdad_pkg::status_type        status_ff;
   logic                        rul_valid_ff;
   logic [23:0]                 rul_ff;

   // window sums
   logic [RA_W-1:0]                    rp_ff, wt_ff;
   logic [RK_W-1:0]                    rk_ff;
   logic                               rdv_ff;
   logic signed [tdad_pkg::WS_W-1:0]   ws_ff;
   logic signed [tdad_pkg::WWS_W-1:0]  wws_ff;
   logic signed [tdad_pkg::NUM_W-1:0]  num_ff;
   logic signed [17:0]                 crit_lvl_ff;

   // output register
   logic                              rsp_valid_ff, rsp_last_ff;
   logic [tdad_pkg::RSP_DATA_W-1:0]   rsp_data_ff;

   // memories
   logic                 store_we;
   logic [BA_W-1:0]      store_waddr, store_raddr;
   logic [31:0]          store_wdata, store_rdata;
   logic                 ring_we;
   logic [RA_W-1:0]      ring_waddr, ring_raddr;
   logic [15:0]          ring_wdata, ring_rdata;

   tdad_ram #(.WIDTH(32), .DEPTH(BASELINE)) u_store (
      .clock (clock), .we (store_we), .waddr (store_waddr), .wdata (store_wdata),
      .raddr (store_raddr), .rdata (store_rdata)
   );

   tdad_ram #(.WIDTH(16), .DEPTH(WINDOW)) u_ring (
      .clock (clock), .we (ring_we), .waddr (ring_waddr), .wdata (ring_wdata),
      .raddr (ring_raddr), .rdata (ring_rdata)
   );

   always_comb begin
      store_we    = (state_ff == S_BASE_ACC) && (bcount_ff < BC_W'(BASELINE));
      store_waddr = bcount_ff[BA_W-1:0];
      store_wdata = {in_temp_ff, in_day_ff};
      store_raddr = idx_ff;
      ring_we     = (state_ff == S_SC_START);
      ring_waddr  = pos_ff;
      ring_wdata  = cur_temp_ff;
      ring_raddr  = rp_ff;
   end

   // divider step: restoring, one quotient bit a cycle
   logic [DW:0]          div_sh, div_rem_in;
   logic [DW-1:0]        div_quo_in;
   logic                 div_ge;
   logic signed [DW:0]   div_sq;

   always_comb begin
      div_sh     = {div_rem_ff[DW-1:0], div_quo_ff[DW-1]};
      div_ge     = div_sh >= {1'b0, div_dvs_ff};
      div_rem_in = div_ge ? div_sh - {1'b0, div_dvs_ff} : div_sh;
      div_quo_in = {div_quo_ff[DW-2:0], div_ge};
      div_sq     = div_neg_ff ? -$signed({1'b0, div_quo_ff}) : $signed({1'b0, div_quo_ff});
   end

   // sqrt step
   logic [31:0] sq_t;
   logic        sq_ge;
   assign sq_t  = sq_r_ff + sq_bit_ff;
   assign sq_ge = sq_v_ff >= sq_t;

   // magnitudes for rounded divides
   logic                              sum_neg;
   logic [tdad_pkg::SUM_W-1:0]        sum_mag;
   logic signed [16:0]                diff;
   logic [16:0]                       diff_mag;
   assign sum_neg  = sum_ff[tdad_pkg::SUM_W-1];
   assign sum_mag  = sum_neg ? $unsigned(-sum_ff) : $unsigned(sum_ff);
   assign diff     = 17'(cur_temp_ff) - 17'(mean_ff);
   assign diff_mag = diff[16] ? $unsigned(-diff) : $unsigned(diff);

   // EWMA rounding
   logic          acc_neg;
   logic [DW:0]   acc_mag;
   logic signed [DW:0] ew_round;
   assign acc_neg  = acc_ff[DW];
   assign acc_mag  = acc_neg ? $unsigned(-acc_ff) : $unsigned(acc_ff);
   assign ew_round = acc_neg ? -$signed((acc_mag + (DW+1)'(32768)) >> 16)
                             : $signed((acc_mag + (DW+1)'(32768)) >> 16);

   // anomaly and status decisions
   logic                 ew_gt;
   logic [15:0]          run_inc;
   logic                 latch_now, flag_next;
   logic [23:0]          warn_lvl;
   logic                 warn_gt;
   logic signed [16:0]   alpha_s;
   logic signed [17:0]   beta_s;
   always_comb begin
      ew_gt     = ewma_ff > $signed({8'd0, thresh_ff});
      run_inc   = (run_ff != 16'hFFFF) ? run_ff + 16'd1 : run_ff;
      latch_now = ew_gt && (run_inc >= sustain_ff) && !flag_ff;
      flag_next = flag_ff || latch_now;
      warn_lvl  = thresh_ff * warn_ff;
      warn_gt   = $signed({ewma_ff, 8'd0}) > $signed({8'd0, warn_lvl});
      alpha_s   = $signed({1'b0, alpha_ff});
      beta_s    = $signed({1'b0, 17'h10000 - {1'b0, alpha_ff}});
   end

   // slope and remaining life
   logic signed [17:0] temp_ext, gap;
   logic               slope_ok;
   logic signed [16:0] wt_s;
   logic signed [15:0] ring_y;
   always_comb begin
      temp_ext = 18'(cur_temp_ff);
      gap      = crit_lvl_ff - temp_ext;
      slope_ok = (48'(num_ff) * 48'sd100) > DEN_X256;
      wt_s     = $signed({1'b0, 16'(wt_ff)});
      ring_y   = $signed(ring_rdata);
   end

   // result start day, clamped
   logic signed [17:0] start_cl;
   always_comb begin
      if (!flag_ff) begin
         start_cl = '0;
      end else if (start_ff > 18'sd65535) begin
         start_cl = 18'sd65535;
      end else if (start_ff < -18'sd65535) begin
         start_cl = -18'sd65535;
      end else begin
         start_cl = start_ff;
      end
   end

   // result handoff: output register empty or draining this cycle
   logic emit_go;
   assign emit_go = (state_ff == S_EMIT) && (!rsp_valid_ff || rsp_tready);

   // main sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         alpha_ff     <= 16'd6554;
         thresh_ff    <= 16'd768;
         sustain_ff   <= 16'd10;
         crit_ff      <= 15'd2048;
         warn_ff      <= 8'd154;
         bcount_ff    <= '0;
         sum_ff       <= '0;
         sumsq_ff     <= '0;
         mean_ff      <= '0;
         dev_ff       <= 16'd1;
         scount_ff    <= '0;
         ewma_ff      <= '0;
         started_ff   <= 1'b0;
         run_ff       <= '0;
         flag_ff      <= 1'b0;
         start_ff     <= '0;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         rdv_ff       <= 1'b0;
      end else begin
         // register writes
         if (csr_we) begin
            case (csr_index)
               tdad_pkg::CSR_ALPHA:   alpha_ff   <= csr_wdata;
               tdad_pkg::CSR_THRESH:  thresh_ff  <= csr_wdata;
               tdad_pkg::CSR_SUSTAIN: sustain_ff <= csr_wdata;
               tdad_pkg::CSR_CRIT:    crit_ff    <= csr_wdata[14:0];
               tdad_pkg::CSR_WARN:    warn_ff    <= csr_wdata[7:0];
               default: ;
            endcase
         end

         // output valid: set on handoff, cleared when taken
         if (emit_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  in_day_ff   <= req_tdata[15:0];
                  in_temp_ff  <= $signed(req_tdata[31:16]);
                  in_end_ff   <= req_tlast;
                  cur_day_ff  <= req_tdata[15:0];
                  cur_temp_ff <= $signed(req_tdata[31:16]);
                  cur_last_ff <= 1'b1;
                  state_ff    <= (scount_ff == '0) ? S_BASE_ACC : S_SC_START;
               end
            end

            // buffer one baseline sample
            S_BASE_ACC: begin
               if (bcount_ff < BC_W'(BASELINE)) begin
                  bcount_ff <= bcount_ff + BC_W'(1);
                  sum_ff    <= sum_ff + tdad_pkg::SUM_W'(in_temp_ff);
                  sumsq_ff  <= sumsq_ff + tdad_pkg::SQ_W'($unsigned(32'(in_temp_ff * in_temp_ff)));
               end
               state_ff <= S_BASE_CHK;
            end

            S_BASE_CHK: begin
               if (bcount_ff >= BC_W'(BASELINE) || in_end_ff) begin
                  state_ff <= S_MEAN_LD;
               end else begin
                  state_ff <= S_FIN;
               end
            end

            // mean = round(sum / n)
            S_MEAN_LD: begin
               div_rem_ff <= '0;
               div_quo_ff <= DW'({sum_mag, 1'b0}) + DW'(bcount_ff);
               div_dvs_ff <= DW'({bcount_ff, 1'b0});
               div_neg_ff <= sum_neg;
               div_cnt_ff <= DC_W'(DW);
               state_ff   <= S_MEAN_DIV;
            end

            S_MEAN_DIV: begin
               if (div_cnt_ff != '0) begin
                  div_rem_ff <= div_rem_in;
                  div_quo_ff <= div_quo_in;
                  div_cnt_ff <= div_cnt_ff - DC_W'(1);
               end else begin
                  mean_ff  <= div_sq[15:0];
                  state_ff <= S_VAR_MUL;
               end
            end

            // variance = (n*sumsq - sum^2) / n^2
            S_VAR_MUL: begin
               prod_a_ff <= $signed(DW'(bcount_ff) * DW'(sumsq_ff));
               prod_b_ff <= DW'(sum_ff) * DW'(sum_ff);
               state_ff  <= S_VAR_LD;
            end

            S_VAR_LD: begin
               div_rem_ff <= '0;
               div_quo_ff <= $unsigned(prod_a_ff - prod_b_ff);
               div_dvs_ff <= DW'(bcount_ff) * DW'(bcount_ff);
               div_neg_ff <= 1'b0;
               div_cnt_ff <= DC_W'(DW);
               state_ff   <= S_VAR_DIV;
            end

            S_VAR_DIV: begin
               if (div_cnt_ff != '0) begin
                  div_rem_ff <= div_rem_in;
                  div_quo_ff <= div_quo_in;
                  div_cnt_ff <= div_cnt_ff - DC_W'(1);
               end else begin
                  sq_v_ff   <= div_quo_ff[31:0];
                  sq_r_ff   <= '0;
                  sq_bit_ff <= 32'h4000_0000;
                  state_ff  <= S_SQRT;
               end
            end

            // integer square root, two bits of radicand a step
            S_SQRT: begin
               if (sq_bit_ff != '0) begin
                  if (sq_ge) begin
                     sq_v_ff <= sq_v_ff - sq_t;
                     sq_r_ff <= (sq_r_ff >> 1) + sq_bit_ff;
                  end else begin
                     sq_r_ff <= sq_r_ff >> 1;
                  end
                  sq_bit_ff <= sq_bit_ff >> 2;
               end else begin
                  if (sq_r_ff == '0) begin
                     dev_ff <= 16'd1;
                  end else if (sq_r_ff > 32'd65535) begin
                     dev_ff <= 16'hFFFF;
                  end else begin
                     dev_ff <= sq_r_ff[15:0];
                  end
                  idx_ff   <= '0;
                  state_ff <= S_SC_RD;
               end
            end

            // replay buffered samples
            S_SC_RD: begin
               state_ff <= S_SC_RDW;
            end

            S_SC_RDW: begin
               cur_day_ff  <= store_rdata[15:0];
               cur_temp_ff <= $signed(store_rdata[31:16]);
               cur_last_ff <= (BC_W'(idx_ff) == bcount_ff - BC_W'(1));
               state_ff    <= S_SC_START;
            end

            // score: ring write, count, z divide
            S_SC_START: begin
               pos_ff <= (pos_ff == RA_W'(WINDOW - 1)) ? '0 : pos_ff + RA_W'(1);
               if (scount_ff < SC_W'(SC_LIMIT)) begin
                  scount_ff <= scount_ff + SC_W'(1);
               end
               div_rem_ff <= '0;
               div_quo_ff <= DW'({diff_mag, 9'd0}) + DW'(dev_ff);
               div_dvs_ff <= DW'({dev_ff, 1'b0});
               div_neg_ff <= diff[16];
               div_cnt_ff <= DC_W'(DW);
               state_ff   <= S_Z_DIV;
            end

            S_Z_DIV: begin
               if (div_cnt_ff != '0) begin
                  div_rem_ff <= div_rem_in;
                  div_quo_ff <= div_quo_in;
                  div_cnt_ff <= div_cnt_ff - DC_W'(1);
               end else begin
                  z_ff     <= tdad_pkg::sat24(div_sq);
                  state_ff <= S_EW1;
               end
            end

            S_EW1: begin
               if (!started_ff) begin
                  ewma_ff    <= z_ff;
                  started_ff <= 1'b1;
                  state_ff   <= S_ANOM;
               end else begin
                  prod_a_ff <= DW'(alpha_s * z_ff);
                  prod_b_ff <= DW'(beta_s * ewma_ff);
                  state_ff  <= S_EW2;
               end
            end

            S_EW2: begin
               acc_ff   <= (DW+1)'(prod_a_ff) + (DW+1)'(prod_b_ff);
               state_ff <= S_EW3;
            end

            S_EW3: begin
               ewma_ff  <= tdad_pkg::sat24(ew_round);
               state_ff <= S_ANOM;
            end

            // run counter, latch, status
            S_ANOM: begin
               if (ew_gt) begin
                  run_ff <= run_inc;
               end else begin
                  run_ff <= '0;
               end
               if (latch_now) begin
                  flag_ff  <= 1'b1;
                  start_ff <= $signed({2'b0, cur_day_ff}) - $signed({2'b0, sustain_ff}) + 18'sd1;
               end
               if (flag_next) begin
                  status_ff <= tdad_pkg::ST_CRITICAL;
               end else if (warn_gt) begin
                  status_ff <= tdad_pkg::ST_WARNING;
               end else begin
                  status_ff <= tdad_pkg::ST_OK;
               end
               rul_valid_ff <= 1'b0;
               rul_ff       <= '0;
               state_ff     <= (scount_ff > SC_W'(2 * WINDOW)) ? S_WIN_INIT : S_EMIT;
            end

            // sum and weighted sum over the ring, oldest first
            S_WIN_INIT: begin
               rp_ff    <= pos_ff;
               rk_ff    <= '0;
               rdv_ff   <= 1'b0;
               ws_ff    <= '0;
               wws_ff   <= '0;
               state_ff <= S_WIN_RD;
            end

            S_WIN_RD: begin
               if (rk_ff < RK_W'(WINDOW)) begin
                  rp_ff  <= (rp_ff == RA_W'(WINDOW - 1)) ? '0 : rp_ff + RA_W'(1);
                  rk_ff  <= rk_ff + RK_W'(1);
                  wt_ff  <= rk_ff[RA_W-1:0];
                  rdv_ff <= 1'b1;
               end else begin
                  rdv_ff <= 1'b0;
               end
               if (rdv_ff) begin
                  ws_ff  <= ws_ff + tdad_pkg::WS_W'(ring_y);
                  wws_ff <= wws_ff + tdad_pkg::WWS_W'(wt_s * ring_y);
               end
               if (rk_ff == RK_W'(WINDOW) && !rdv_ff) begin
                  state_ff <= S_SLOPE1;
               end
            end

            S_SLOPE1: begin
               num_ff <= tdad_pkg::NUM_W'(wws_ff) * tdad_pkg::NUM_W'(WINDOW)
                       - tdad_pkg::NUM_W'(ws_ff) * tdad_pkg::NUM_W'(WIN_SX);
               crit_lvl_ff <= 18'(mean_ff) + 18'($signed({1'b0, crit_ff}));
               state_ff    <= S_SLOPE2;
            end

            S_SLOPE2: begin
               if (temp_ext >= crit_lvl_ff) begin
                  rul_valid_ff <= 1'b1;
                  rul_ff       <= '0;
                  state_ff     <= S_EMIT;
               end else if (slope_ok) begin
                  div_rem_ff <= '0;
                  div_quo_ff <= DW'({tdad_pkg::NUM_W'(gap[16:0]) * tdad_pkg::NUM_W'(DEN_C),
                                     8'd0});
                  div_dvs_ff <= DW'($unsigned(num_ff));
                  div_neg_ff <= 1'b0;
                  div_cnt_ff <= DC_W'(DW);
                  state_ff   <= S_RUL_DIV;
               end else begin
                  state_ff <= S_EMIT;
               end
            end

            S_RUL_DIV: begin
               if (div_cnt_ff != '0) begin
                  div_rem_ff <= div_rem_in;
                  div_quo_ff <= div_quo_in;
                  div_cnt_ff <= div_cnt_ff - DC_W'(1);
               end else begin
                  rul_valid_ff <= 1'b1;
                  rul_ff       <= (|div_quo_ff[DW-1:24]) ? 24'hFFFFFF : div_quo_ff[23:0];
                  state_ff     <= S_EMIT;
               end
            end

            // hand the result word to the output register
            S_EMIT: begin
               if (emit_go) begin
                  rsp_last_ff  <= cur_last_ff;
                  rsp_data_ff  <= {3'b0, rul_ff, rul_valid_ff, start_cl[16:0], flag_ff,
                                   status_ff, ewma_ff, z_ff, cur_day_ff};
                  if (cur_last_ff) begin
                     state_ff <= S_FIN;
                  end else begin
                     idx_ff   <= idx_ff + BA_W'(1);
                     state_ff <= S_SC_RD;
                  end
               end
            end

            // back to idle; at end of series, restart series state and keep configuration
            S_FIN: begin
               if (in_end_ff) begin
                  bcount_ff  <= '0;
                  sum_ff     <= '0;
                  sumsq_ff   <= '0;
                  mean_ff    <= '0;
                  dev_ff     <= 16'd1;
                  scount_ff  <= '0;
                  ewma_ff    <= '0;
                  started_ff <= 1'b0;
                  run_ff     <= '0;
                  flag_ff    <= 1'b0;
                  start_ff   <= '0;
                  pos_ff     <= '0;
               end
               state_ff <= S_IDLE;
            end

            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

### hdl/tdad_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.

module tdad_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 20,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rd_ff <= mem_ff[raddr];
   end

   assign rdata = rd_ff;

endmodule

### hdl/tdad_chk.sv
// Port-level checker for the drift anomaly detector, bound to the top level.
// Depends on tdad_pkg for the result word layout.

module tdad_chk (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_tready,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [tdad_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input logic                               rsp_tlast
);

   logic [1:0]                     status;
   logic                           found, rulv;
   logic [tdad_pkg::START_W-1:0]   start;
   logic [tdad_pkg::RUL_W-1:0]     rul;

   assign status = rsp_tdata[tdad_pkg::RSP_STATUS_LSB +: 2];
   assign found  = rsp_tdata[tdad_pkg::RSP_FOUND_BIT];
   assign rulv   = rsp_tdata[tdad_pkg::RSP_RULV_BIT];
   assign start  = rsp_tdata[tdad_pkg::RSP_START_LSB +: tdad_pkg::START_W];
   assign rul    = rsp_tdata[tdad_pkg::RSP_RUL_LSB +: tdad_pkg::RUL_W];

   // stalled result word holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result word changed while stalled");

   // no latched anomaly: no start day and not critical
   a_nofound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !found |-> start == '0 && status != tdad_pkg::ST_CRITICAL)
      else $error("start day or critical status without anomaly");

   // latched anomaly always reports critical
   a_found: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && found |-> status == tdad_pkg::ST_CRITICAL)
      else $error("anomaly without critical status");

   // remaining life is zero when not valid
   a_rul: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rulv |-> rul == '0)
      else $error("remaining life set without valid");

   // after reset: nothing pending, input open
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("block not idle after reset");

endmodule

bind telemetry_drift_anomaly_detector_unit tdad_chk u_tdad_chk (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

### tb/tdad_checker.sv
// Result checker for the drift anomaly detector: predicts every result word and compares.
// Depends on tdad_pkg; watches the request, result and register ports of the unit.

module tdad_checker #(
   parameter int BASELINE = 20,
   parameter int WINDOW   = 14
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   input  logic [tdad_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                            req_tlast,
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic [tdad_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                            rsp_tlast,
   input  logic                            csr_we,
   input  logic [tdad_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [tdad_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                              fail_count,
   output int                              pending
);

   localparam longint ZHI = 64'sd8388607;
   localparam longint ZLO = -64'sd8388608;
   localparam int     QDEPTH = 64;

   typedef struct {
      logic [15:0]          day;
      logic signed [23:0]   z;
      logic signed [23:0]   ewma;
      tdad_pkg::status_type status;
      logic                 found;
      logic signed [16:0]   start;
      logic                 rulv;
      logic [23:0]          rul;
      logic                 last;
   } drift_result_type;

   // expected words, oldest at exp_head
   drift_result_type exp_mem[QDEPTH];
   int               exp_head, exp_count;
   int               fails;

   // register copies
   longint alpha, thresh, sustain, crit_off, warn;

   // series state
   logic [15:0] buf_day[BASELINE];
   longint      buf_temp[BASELINE];
   longint      ring[WINDOW];
   int          base_cnt, ring_pos;
   longint      base_sum, base_sq, mean, dev, ewma, start_day;
   longint unsigned scored;
   int unsigned run_len;
   logic        ewma_started, latched;

   function automatic longint round_div(longint num, longint den);
      longint mag, q;
      mag = (num < 0) ? -num : num;
      q = (2 * mag + den) / (2 * den);
      return (num < 0) ? -q : q;
   endfunction

   function automatic longint clamp24(longint v);
      return (v > ZHI) ? ZHI : ((v < ZLO) ? ZLO : v);
   endfunction

   function automatic longint int_sqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return longint'(r);
   endfunction

   function automatic void add_expected(drift_result_type r);
      if (exp_count >= QDEPTH) begin
         $error("expected word store overflow");
         fails++;
      end else begin
         exp_mem[(exp_head + exp_count) % QDEPTH] = r;
         exp_count++;
      end
   endfunction

   function automatic drift_result_type take_expected();
      drift_result_type r;
      r = exp_mem[exp_head];
      exp_head = (exp_head + 1) % QDEPTH;
      exp_count--;
      return r;
   endfunction

   function automatic void clear_series();
      base_cnt = 0;
      base_sum = 0;
      base_sq = 0;
      mean = 0;
      dev = 1;
      scored = 0;
      ewma = 0;
      ewma_started = 1'b0;
      run_len = 0;
      latched = 1'b0;
      start_day = 0;
      ring_pos = 0;
      foreach (ring[i]) ring[i] = 0;
   endfunction

   // score one sample and queue its expected result word
   function automatic void score_sample(logic [15:0] day, longint t);
      drift_result_type r;
      longint z, s, wsum, wws, num, critical, y;
      z = clamp24(round_div((t - mean) * 256, dev));
      if (!ewma_started) begin
         ewma = z;
         ewma_started = 1'b1;
      end else begin
         ewma = clamp24(round_div(alpha * z + (65536 - alpha) * ewma, 65536));
      end
      if (ewma > thresh) begin
         if (run_len < 65535) run_len++;
         if (longint'(run_len) >= sustain && !latched) begin
            latched = 1'b1;
            start_day = longint'(day) - sustain + 1;
         end
      end else begin
         run_len = 0;
      end
      ring[ring_pos] = t;
      ring_pos = (ring_pos + 1) % WINDOW;
      if (scored < 64'hFFFF_FFFF) scored++;

      r.day = day;
      r.z = z[23:0];
      r.ewma = ewma[23:0];
      if (latched) r.status = tdad_pkg::ST_CRITICAL;
      else if (ewma * 256 > thresh * warn) r.status = tdad_pkg::ST_WARNING;
      else r.status = tdad_pkg::ST_OK;
      r.found = latched;
      s = latched ? start_day : 0;
      if (s > 65535) s = 65535;
      if (s < -65535) s = -65535;
      r.start = s[16:0];
      r.rulv = 1'b0;
      r.rul = '0;
      r.last = 1'b0;

      // least-squares slope over the last WINDOW samples, oldest at x = 0
      if (scored > 2 * WINDOW) begin
         longint sx, sxx, den;
         wsum = 0;
         wws = 0;
         for (int i = 0; i < WINDOW; i++) begin
            y = ring[(ring_pos + i) % WINDOW];
            wsum += y;
            wws += i * y;
         end
         sx = WINDOW * (WINDOW - 1) / 2;
         sxx = (WINDOW - 1) * WINDOW * (2 * WINDOW - 1) / 6;
         den = WINDOW * sxx - sx * sx;
         num = WINDOW * wws - sx * wsum;
         critical = mean + crit_off;
         if (t >= critical) begin
            r.rulv = 1'b1;
         end else if (den > 0 && 100 * num > 256 * den) begin
            y = (critical - t) * 256 * den / num;
            r.rulv = 1'b1;
            r.rul = (y > 64'hFF_FFFF) ? 24'hFF_FFFF : y[23:0];
         end
      end
      add_expected(r);
   endfunction

   function automatic void check_field(string name, longint exp, longint act);
      if (exp != act) begin
         $error("%s: expected %0d, actual %0d", name, exp, act);
         fails++;
      end
   endfunction

   always @(posedge clock) begin
      logic [15:0] d;
      longint t, n, v;
      int before_n;
      drift_result_type e;
      if (reset) begin
         alpha = 6554;
         thresh = 768;
         sustain = 10;
         crit_off = 2048;
         warn = 154;
         clear_series();
         exp_head = 0;
         exp_count = 0;
         fails = 0;
      end else begin
         // register writes
         if (csr_we) begin
            case (csr_index)
               tdad_pkg::CSR_ALPHA:   alpha = csr_wdata;
               tdad_pkg::CSR_THRESH:  thresh = csr_wdata;
               tdad_pkg::CSR_SUSTAIN: sustain = csr_wdata;
               tdad_pkg::CSR_CRIT:    crit_off = csr_wdata[14:0];
               tdad_pkg::CSR_WARN:    warn = csr_wdata[7:0];
               default: ;
            endcase
         end

         // compare result word against oldest expectation
         if (rsp_tvalid && rsp_tready) begin
            if (exp_count == 0) begin
               $error("unexpected result word for day %0d", rsp_tdata[15:0]);
               fails++;
            end else begin
               e = take_expected();
               check_field("sample_day", e.day, rsp_tdata[tdad_pkg::RSP_DAY_LSB +: 16]);
               check_field("z_score", e.z, $signed(rsp_tdata[tdad_pkg::RSP_Z_LSB +: 24]));
               check_field("smoothed_z", e.ewma,
                           $signed(rsp_tdata[tdad_pkg::RSP_EWMA_LSB +: 24]));
               check_field("status", e.status, rsp_tdata[tdad_pkg::RSP_STATUS_LSB +: 2]);
               check_field("anomaly_found", e.found, rsp_tdata[tdad_pkg::RSP_FOUND_BIT]);
               check_field("start_day", e.start,
                           $signed(rsp_tdata[tdad_pkg::RSP_START_LSB +: 17]));
               check_field("rul_valid", e.rulv, rsp_tdata[tdad_pkg::RSP_RULV_BIT]);
               check_field("rul_days", e.rul, rsp_tdata[tdad_pkg::RSP_RUL_LSB +: 24]);
               check_field("last_result", e.last, rsp_tlast);
            end
         end

         // predict results of an accepted sample word
         if (req_tvalid && req_tready) begin
            d = req_tdata[15:0];
            t = $signed(req_tdata[31:16]);
            before_n = exp_count;
            if (scored == 0) begin
               if (base_cnt < BASELINE) begin
                  buf_day[base_cnt] = d;
                  buf_temp[base_cnt] = t;
                  base_cnt++;
                  base_sum += t;
                  base_sq += t * t;
               end
               if (base_cnt >= BASELINE || req_tlast) begin
                  n = base_cnt;
                  mean = round_div(base_sum, n);
                  v = (n * base_sq - base_sum * base_sum) / (n * n);
                  if (v < 0) v = 0;
                  dev = int_sqrt(v);
                  if (dev < 1) dev = 1;
                  if (dev > 65535) dev = 65535;
                  for (int i = 0; i < base_cnt; i++) score_sample(buf_day[i], buf_temp[i]);
               end
            end else begin
               score_sample(d, t);
            end
            if (exp_count > before_n) begin
               exp_mem[(exp_head + exp_count - 1) % QDEPTH].last = 1'b1;
            end
            if (req_tlast) clear_series();
         end
      end
      fail_count <= fails;
      pending <= exp_count;
   end

endmodule

### tb/tb_top.sv
// Testbench top for the drift anomaly detector: clock, reset, stimulus and verdict.
// Depends on tdad_pkg, the unit under test and tdad_checker.

module tb_top;

   localparam logic [tdad_pkg::CSR_IDX_W-1:0] CSR_UNUSED = 3'd7;
   localparam int SETTLE_CYCLES = 400;

   logic                            clock = 1'b0;
   logic                            reset;
   logic                            req_tvalid, req_tready, req_tlast;
   logic [tdad_pkg::REQ_DATA_W-1:0] req_tdata;
   logic                            rsp_tvalid, rsp_tready, rsp_tlast;
   logic [tdad_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                            csr_we;
   logic [tdad_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [tdad_pkg::CSR_DATA_W-1:0] csr_wdata;
   int                              fail_count, pending;
   int                              send_idle, recv_idle;

   telemetry_drift_anomaly_detector_unit dut (.*);

   tdad_checker chk (.*);

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      #(12 * 1500000);
      $display("** telemetry_drift_anomaly_detector_unit: FAILED **");
      $finish;
   end

   // receiver stalls
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle);
   end

   // one sample word, with random sender gaps before it
   task automatic send_sample(input logic [15:0] d, input logic signed [15:0] t,
                              input logic e);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {t, d};
      req_tlast <= e;
      do @(posedge clock); while (!req_tready);
   endtask

   // wait for every result, then let any buffering work finish
   task automatic drain();
      req_tvalid <= 1'b0;
      repeat (2) @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_settings(input logic [15:0] a, th, su, cr, wr);
      logic [15:0] vals[6];
      logic [tdad_pkg::CSR_IDX_W-1:0] idx[6];
      vals = '{a, th, su, cr, wr, 16'hFFFF};
      idx = '{tdad_pkg::CSR_ALPHA, tdad_pkg::CSR_THRESH, tdad_pkg::CSR_SUSTAIN,
              tdad_pkg::CSR_CRIT, tdad_pkg::CSR_WARN, CSR_UNUSED};
      for (int i = 0; i < 6; i++) begin
         csr_we <= 1'b1;
         csr_index <= idx[i];
         csr_wdata <= vals[i];
         @(posedge clock);
      end
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic pick_settings();
      case ($urandom_range(4))
         0: write_settings(16'd6554, 16'd768, 16'd10, 16'd2048, 16'd154);
         1: write_settings(16'hFFFF, 16'd0, 16'd1, 16'd0, 16'd255);
         2: write_settings(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
         3: write_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h7FFF, 16'd255);
         default: write_settings(16'($urandom_range(1, 65535)),
                                 16'($urandom_range(200, 2000)),
                                 16'($urandom_range(1, 12)), 16'($urandom_range(0, 4000)),
                                 16'($urandom_range(255)));
      endcase
   endtask

   // well-formed series: level baseline with noise, then an optional upward drift
   task automatic long_series(output int sent);
      int len, base, amp, slope, t;
      logic [15:0] d;
      len = $urandom_range(30, 48);
      base = int'($urandom_range(12000)) - 6000;
      amp = $urandom_range(1, 300);
      slope = $urandom_range(0, 400);
      d = 16'($urandom);
      for (int k = 0; k < len; k++) begin
         t = base + int'($urandom_range(2 * amp)) - amp;
         if (k >= 20) t += (k - 19) * slope;
         if (t > 32767) t = 32767;
         if (t < -32768) t = -32768;
         send_sample(d, t[15:0], k == len - 1);
         d++;
      end
      sent = len;
   endtask

   initial begin
      int sent, total;
      reset = 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      req_tlast <= 1'b0;
      csr_we <= 1'b0;
      csr_index <= tdad_pkg::CSR_ALPHA;
      csr_wdata <= '0;
      send_idle = 11;
      recv_idle = 85;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      write_settings(16'd6554, 16'd768, 16'd10, 16'd2048, 16'd154);

      // single-sample series, two-sample extreme series with day wrap
      send_sample(16'd0, -16'sd32768, 1'b1);
      send_sample(16'hFFFF, 16'sh7FFF, 1'b0);
      send_sample(16'd0, -16'sd32768, 1'b1);
      // flat full baseline (deviation floor), then extreme z both ways (the low one saturates)
      for (int k = 0; k < 20; k++) send_sample(k[15:0], 16'sh0100, 1'b0);
      send_sample(16'd20, 16'sh7FFF, 1'b0);
      send_sample(16'd21, -16'sd32768, 1'b1);
      drain();

      total = 0;
      for (int phase = 0; phase < 3; phase++) begin
         send_idle = (phase == 0) ? 11 : ((phase == 1) ? 85 : 0);
         recv_idle = (phase == 0) ? 85 : ((phase == 1) ? 11 : 0);
         while (total < 60 * (phase + 1)) begin
            if ($urandom_range(99) < 40) begin
               drain();
               pick_settings();
            end
            case ($urandom_range(9))
               0, 1: begin
                  // series ending inside the baseline
                  sent = $urandom_range(1, 20);
                  for (int k = 0; k < sent; k++)
                     send_sample(16'($urandom), 16'($urandom_range(2000) - 1000),
                                 k == sent - 1);
               end
               2: begin
                  // noise: any day, any temperature, random end marks
                  sent = $urandom_range(1, 5);
                  for (int k = 0; k < sent; k++)
                     send_sample(16'($urandom), 16'($urandom), 1'($urandom_range(1)));
               end
               default: long_series(sent);
            endcase
            total += sent;
         end
      end
      drain();

      if (fail_count == 0 && pending == 0) begin
         $display("** telemetry_drift_anomaly_detector_unit: PASSED **");
      end else begin
         $display("** telemetry_drift_anomaly_detector_unit: FAILED **");
      end
      $finish;
   end

endmodule

### telemetry_drift_anomaly_detector_unit.f
hdl/tdad_pkg.sv
hdl/tdad_ram.sv
hdl/telemetry_drift_anomaly_detector_unit.sv
hdl/tdad_chk.sv
tb/tdad_checker.sv
tb/tb_top.sv
